// ----- src/disparity_to_point_reproject_defines.svh -----
// Assertion macros used by the checker file.
`ifndef DISPARITY_TO_POINT_REPROJECT_DEFINES_SVH
`define DISPARITY_TO_POINT_REPROJECT_DEFINES_SVH

// Antecedent implies consequent in the same cycle, checked outside reset.
`define DTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dtp assertion failed");

// Antecedent implies consequent in the next cycle, checked outside reset.
`define DTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dtp assertion failed");

`endif

// ----- src/dtp_pkg.sv -----
package dtp_pkg;

	// Field widths.
	localparam int DISP_W      = 16;
	localparam int GRAY_W      = 8;
	localparam int COORD_W     = 12;
	localparam int FRAC_W      = 4;
	localparam int FOCAL_W     = 16;
	localparam int CENTER_W    = 16;
	localparam int BASE_W      = 20;
	localparam int DEPTH_W     = 24;
	localparam int LAT_W       = 32;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 24;

	// Shared divider geometry: one quotient bit per stage.
	localparam int DIVD_W      = 41;
	localparam int DIVS_W      = 16;
	localparam int TAG_W       = 1 + DEPTH_W + GRAY_W + 2 * COORD_W;
	localparam int FB_W        = FOCAL_W + BASE_W;
	localparam int OFF_W       = COORD_W + FRAC_W + 1;
	localparam int PROD_W      = (OFF_W - 1) + DEPTH_W;

	// Accept edge to the edge that takes the result.
	localparam int LATENCY     = 2 * DIVD_W + 5;

	// Register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_FOCAL  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CX     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CY     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_BASE   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_MAXD   = 3'd4;

	typedef struct packed {
		logic [FOCAL_W-1:0]  focal;
		logic [CENTER_W-1:0] cx;
		logic [CENTER_W-1:0] cy;
		logic [BASE_W-1:0]   base;
		logic [DEPTH_W-1:0]  maxd;
	} cfg_t;

endpackage

// ----- src/disparity_to_point_reproject.sv -----
// Channel   Direction  Handshake              Payload
// input     in         start / busy           disparity, intensity, pixel_row, pixel_col
// config    in         cfg_valid / cfg_ready  cfg_addr, cfg_data
// result    out        result_valid strobe    x_um, y_um, z_um, gray, out_row, out_col
//
// One item enters per clock; busy is high in reset and until the first clock after release.
// A result strobes once its item has passed through two 41-stage
// bit-per-stage dividers (depth, then lateral) plus five pipeline registers.
// Items with non-positive disparity or too deep a point give no strobe.
// The receiver cannot stall; the pipeline never holds. Reset clears all valid bits.
module disparity_to_point_reproject (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [15:0]             disparity,
	input  logic [7:0]                     intensity,
	input  logic [11:0]                    pixel_row,
	input  logic [11:0]                    pixel_col,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dtp_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [dtp_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           result_valid,
	output logic signed [31:0]             x_um,
	output logic signed [31:0]             y_um,
	output logic [23:0]                    z_um,
	output logic [7:0]                     gray,
	output logic [11:0]                    out_row,
	output logic [11:0]                    out_col
);
	import dtp_pkg::*;

	cfg_t cfg;
	logic busy_q;

	// Busy only until the first clock after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	dtp_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// Stage 1: take the item; only positive disparities stay valid.
	logic               vld_s1;
	logic [DISP_W-2:0]  disp_s1;
	logic [GRAY_W-1:0]  gray_s1;
	logic [COORD_W-1:0] row_s1, col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy_q && !disparity[DISP_W-1] && (disparity != '0);
		end
	end

	always_ff @(posedge clk) begin
		disp_s1 <= disparity[DISP_W-2:0];
		gray_s1 <= intensity;
		row_s1  <= pixel_row;
		col_s1  <= pixel_col;
	end

	// Stage 2: depth numerator focal times baseline.
	logic               vld_s2;
	logic [FB_W-1:0]    fb_s2;
	logic [DISP_W-2:0]  disp_s2;
	logic [GRAY_W-1:0]  gray_s2;
	logic [COORD_W-1:0] row_s2, col_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		fb_s2   <= FB_W'(cfg.focal * cfg.base);
		disp_s2 <= disp_s1;
		gray_s2 <= gray_s1;
		row_s2  <= row_s1;
		col_s2  <= col_s1;
	end

	// Depth divider: z = focal * baseline / disparity.
	logic              zd_vld;
	logic [DIVD_W-1:0] zd_q;
	logic [TAG_W-1:0]  zd_tag;

	dtp_div u_zdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s2),
		.dividend(DIVD_W'(fb_s2)),
		.divisor (DIVS_W'(disp_s2)),
		.in_tag  (TAG_W'({gray_s2, row_s2, col_s2})),
		.out_vld (zd_vld),
		.quotient(zd_q),
		.out_tag (zd_tag)
	);

	// Stage 3: depth limit and signed offsets from the principal point.
	logic               zd_ok;
	logic [OFF_W-1:0]   offx, offy;
	logic [COORD_W-1:0] zrow, zcol;
	logic               vld_s3;
	logic [DEPTH_W-1:0] z_s3;
	logic               sx_s3, sy_s3;
	logic [OFF_W-2:0]   mx_s3, my_s3;
	logic [GRAY_W-1:0]  gray_s3;
	logic [COORD_W-1:0] row_s3, col_s3;

	assign zcol  = zd_tag[COORD_W-1:0];
	assign zrow  = zd_tag[2*COORD_W-1:COORD_W];
	assign zd_ok = (zd_q[DIVD_W-1:DEPTH_W] == '0) && (zd_q[DEPTH_W-1:0] <= cfg.maxd);
	assign offx  = {1'b0, zcol, FRAC_W'(0)} - {1'b0, cfg.cx};
	assign offy  = {1'b0, zrow, FRAC_W'(0)} - {1'b0, cfg.cy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= zd_vld && zd_ok;
		end
	end

	always_ff @(posedge clk) begin
		z_s3    <= zd_q[DEPTH_W-1:0];
		sx_s3   <= offx[OFF_W-1];
		sy_s3   <= offy[OFF_W-1];
		mx_s3   <= offx[OFF_W-1] ? (OFF_W-1)'(-offx) : offx[OFF_W-2:0];
		my_s3   <= offy[OFF_W-1] ? (OFF_W-1)'(-offy) : offy[OFF_W-2:0];
		gray_s3 <= zd_tag[TAG_W-DEPTH_W-2:2*COORD_W];
		row_s3  <= zrow;
		col_s3  <= zcol;
	end

	// Stage 4: offset magnitude times depth.
	logic               vld_s4;
	logic [PROD_W-1:0]  px_s4, py_s4;
	logic               sx_s4, sy_s4;
	logic [DEPTH_W-1:0] z_s4;
	logic [GRAY_W-1:0]  gray_s4;
	logic [COORD_W-1:0] row_s4, col_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		px_s4   <= mx_s3 * z_s3;
		py_s4   <= my_s3 * z_s3;
		sx_s4   <= sx_s3;
		sy_s4   <= sy_s3;
		z_s4    <= z_s3;
		gray_s4 <= gray_s3;
		row_s4  <= row_s3;
		col_s4  <= col_s3;
	end

	// Lateral dividers by the focal length; x carries the sideband.
	logic              xd_vld, yd_vld;
	logic [DIVD_W-1:0] xd_q, yd_q;
	logic [TAG_W-1:0]  xd_tag, yd_tag;

	dtp_div u_xdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s4),
		.dividend(DIVD_W'(px_s4)),
		.divisor (cfg.focal),
		.in_tag  ({sx_s4, z_s4, gray_s4, row_s4, col_s4}),
		.out_vld (xd_vld),
		.quotient(xd_q),
		.out_tag (xd_tag)
	);

	dtp_div u_ydiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s4),
		.dividend(DIVD_W'(py_s4)),
		.divisor (cfg.focal),
		.in_tag  ({sy_s4, (TAG_W-1)'(0)}),
		.out_vld (yd_vld),
		.quotient(yd_q),
		.out_tag (yd_tag)
	);

	// Restore the sign and clamp a magnitude quotient to 32 bits.
	function automatic logic [LAT_W-1:0] sat_signed(input logic neg, input logic [DIVD_W-1:0] q);
		logic [LAT_W-1:0] res;
		if (neg) begin
			if (q > DIVD_W'(64'h8000_0000)) begin
				res = 32'h8000_0000;
			end else begin
				res = -q[LAT_W-1:0];
			end
		end else begin
			if (q > DIVD_W'(64'h7fff_ffff)) begin
				res = 32'h7fff_ffff;
			end else begin
				res = q[LAT_W-1:0];
			end
		end
		return res;
	endfunction

	// Stage 5: output register.
	logic               vld_s5;
	logic [LAT_W-1:0]   x_s5, y_s5;
	logic [DEPTH_W-1:0] z_s5;
	logic [GRAY_W-1:0]  gray_s5;
	logic [COORD_W-1:0] row_s5, col_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= xd_vld && yd_vld;
		end
	end

	always_ff @(posedge clk) begin
		x_s5    <= (cfg.focal == '0) ? '0 : sat_signed(xd_tag[TAG_W-1], xd_q);
		y_s5    <= (cfg.focal == '0) ? '0 : sat_signed(yd_tag[TAG_W-1], yd_q);
		z_s5    <= xd_tag[TAG_W-2:TAG_W-1-DEPTH_W];
		gray_s5 <= xd_tag[TAG_W-DEPTH_W-2:2*COORD_W];
		row_s5  <= xd_tag[2*COORD_W-1:COORD_W];
		col_s5  <= xd_tag[COORD_W-1:0];
	end

	assign result_valid = vld_s5;
	assign x_um         = x_s5;
	assign y_um         = y_s5;
	assign z_um         = z_s5;
	assign gray         = gray_s5;
	assign out_row      = row_s5;
	assign out_col      = col_s5;

endmodule

// ----- src/dtp_regs.sv -----
module dtp_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [dtp_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [dtp_pkg::CFG_DATA_W-1:0] cfg_data,
	output dtp_pkg::cfg_t                  cfg
);
	import dtp_pkg::*;

	cfg_t cfg_q;

	// Register file, written whenever a write arrives; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal <= FOCAL_W'(4624);
			cfg_q.cx    <= CENTER_W'(4922);
			cfg_q.cy    <= CENTER_W'(3770);
			cfg_q.base  <= BASE_W'(110000);
			cfg_q.maxd  <= DEPTH_W'(15000000);
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				REG_FOCAL: cfg_q.focal <= cfg_data[FOCAL_W-1:0];
				REG_CX:    cfg_q.cx    <= cfg_data[CENTER_W-1:0];
				REG_CY:    cfg_q.cy    <= cfg_data[CENTER_W-1:0];
				REG_BASE:  cfg_q.base  <= cfg_data[BASE_W-1:0];
				REG_MAXD:  cfg_q.maxd  <= cfg_data[DEPTH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/dtp_div.sv -----
module dtp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [dtp_pkg::DIVD_W-1:0] dividend,
	input  logic [dtp_pkg::DIVS_W-1:0] divisor,
	input  logic [dtp_pkg::TAG_W-1:0]  in_tag,
	output logic                       out_vld,
	output logic [dtp_pkg::DIVD_W-1:0] quotient,
	output logic [dtp_pkg::TAG_W-1:0]  out_tag
);
	import dtp_pkg::*;

	// One restoring step per stage; the dividend shifts out as quotient bits shift in.
	logic              vld_s [DIVD_W];
	logic [DIVS_W-1:0] rem_s [DIVD_W];
	logic [DIVD_W-1:0] dq_s  [DIVD_W];
	logic [DIVS_W-1:0] dvs_s [DIVD_W];
	logic [TAG_W-1:0]  tag_s [DIVD_W];

	for (genvar k = 0; k < DIVD_W; k++) begin : g_stage
		logic              p_vld;
		logic [DIVS_W-1:0] p_rem;
		logic [DIVD_W-1:0] p_dq;
		logic [DIVS_W-1:0] p_dvs;
		logic [TAG_W-1:0]  p_tag;
		logic [DIVS_W:0]   trial;
		logic              fits;

		if (k == 0) begin : g_first
			assign p_vld = in_vld;
			assign p_rem = '0;
			assign p_dq  = dividend;
			assign p_dvs = divisor;
			assign p_tag = in_tag;
		end else begin : g_next
			assign p_vld = vld_s[k-1];
			assign p_rem = rem_s[k-1];
			assign p_dq  = dq_s[k-1];
			assign p_dvs = dvs_s[k-1];
			assign p_tag = tag_s[k-1];
		end

		// Trial subtract of the divisor from the shifted remainder.
		assign trial = {p_rem, p_dq[DIVD_W-1]};
		assign fits  = (trial >= {1'b0, p_dvs});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= fits ? DIVS_W'(trial - {1'b0, p_dvs}) : trial[DIVS_W-1:0];
			dq_s[k]  <= {p_dq[DIVD_W-2:0], fits};
			dvs_s[k] <= p_dvs;
			tag_s[k] <= p_tag;
		end
	end

	assign out_vld  = vld_s[DIVD_W-1];
	assign quotient = dq_s[DIVD_W-1];
	assign out_tag  = tag_s[DIVD_W-1];

endmodule

// ----- src/dtp_checker.sv -----
`include "disparity_to_point_reproject_defines.svh"

module dtp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic signed [15:0]             disparity,
	input logic [7:0]                     intensity,
	input logic [11:0]                    pixel_row,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic                           result_valid,
	input logic signed [31:0]             x_um,
	input logic signed [31:0]             y_um,
	input logic [23:0]                    z_um,
	input logic [7:0]                     gray,
	input logic [11:0]                    out_row
);
	import dtp_pkg::*;

	// A result always traces back to a taken item with positive disparity.
	`DTP_ASSERT_IMP(a_src, clk, arst_n, result_valid, $past(start && !busy && !disparity[15] && (disparity != 16'sd0), LATENCY))
	// The sideband comes out with its own item.
	`DTP_ASSERT_IMP(a_side, clk, arst_n, result_valid, (gray == $past(intensity, LATENCY)) && (out_row == $past(pixel_row, LATENCY)))
	// Zero depth means the point sits on the camera center.
	`DTP_ASSERT_IMP(a_zero, clk, arst_n, result_valid && (z_um == 24'd0), (x_um == 32'sd0) && (y_um == 32'sd0))
	// Once out of reset the block keeps taking items and writes.
	`DTP_ASSERT_NXT(a_free, clk, arst_n, !busy, !busy && cfg_ready)

endmodule

bind disparity_to_point_reproject dtp_checker u_dtp_checker (.*);
